### design/polar_offset_degrees_defines.svh
// Assertion macros shared by the checker files of polar_offset_degrees.
`ifndef POLAR_OFFSET_DEGREES_DEFINES_SVH
`define POLAR_OFFSET_DEGREES_DEFINES_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define POD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("polar_offset_degrees assertion failed");

// Same, on the block's own clock and reset names.
`define POD_ASSERT_CLK(label, prop) \
  `POD_ASSERT(label, clk_i, rst_ni, prop)

`endif

### design/pod_pkg.sv
// Types and constant tables shared by the polar offset pipeline.
package pod_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned AngleFrac = 22;
  localparam int unsigned DataW     = 42;
  localparam int unsigned ZW        = 32;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } pod_quad_e;

  // Per-stage rotation angles atan(2^-i) in degrees, 22 fractional bits.
  localparam logic [31:0] POD_ATAN_DEG [0:MaxStages-1] = '{
    32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
    32'd7507429,   32'd3754631,   32'd1877430,  32'd938729,   32'd469366,
    32'd234683,    32'd117342,    32'd58671,    32'd29335,    32'd14668,
    32'd7334,      32'd3667,      32'd1833,     32'd917,      32'd458,
    32'd229,       32'd115,       32'd57,       32'd29
  };

  // Inverse rotation gain for a given stage count, 30 fractional bits.
  localparam logic [31:0] POD_GAIN [0:MaxStages] = '{
    32'd1073741824, 32'd759250125, 32'd679093956, 32'd658817909, 32'd653730436,
    32'd652457347,  32'd652138997, 32'd652059405, 32'd652039507, 32'd652034532,
    32'd652033289,  32'd652032978, 32'd652032900, 32'd652032881, 32'd652032876,
    32'd652032874,  32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
    32'd652032874,  32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874
  };

  // Item state while the angle is being wrapped into one turn.
  typedef struct packed {
    logic [31:0]        rem;
    logic signed [23:0] radius;
  } pod_wrap_t;

  // Item state inside the rotation chain.
  typedef struct packed {
    pod_quad_e                quad;
    logic signed [DataW-1:0]  x;
    logic signed [DataW-1:0]  y;
    logic signed [ZW-1:0]     z;
  } pod_rot_t;

endpackage

### design/pod_wrap_cell.sv
// One step of the angle wrap: conditional subtract of a shifted full turn.
module pod_wrap_cell #(
  parameter logic [32:0] SUB = 33'd92160
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pod_pkg::pod_wrap_t data_i,
  output logic              valid_o,
  output pod_pkg::pod_wrap_t data_o
);
  import pod_pkg::*;

  logic      valid_q;
  pod_wrap_t data_q, data_d;
  logic [32:0] diff;

  always_comb begin
    diff   = {1'b0, data_i.rem} - SUB;
    data_d = data_i;
    if (!diff[32]) begin
      data_d.rem = diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/pod_rot_cell.sv
// One rotation stage: shift-and-add micro-rotation towards zero residual angle.
module pod_rot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pod_pkg::pod_rot_t data_i,
  output logic             valid_o,
  output pod_pkg::pod_rot_t data_o
);
  import pod_pkg::*;

  localparam logic signed [ZW-1:0] Atan = signed'(POD_ATAN_DEG[STAGE]);

  logic                    valid_q;
  pod_rot_t                data_q, data_d;
  logic signed [DataW-1:0] dx, dy;

  always_comb begin
    dx     = data_i.y >>> STAGE;
    dy     = data_i.x >>> STAGE;
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - Atan;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/polar_offset_degrees.sv
// Top level of the polar to Cartesian offset pipeline.
//
// Takes one item per cycle while in_stall_o is low and returns
// offset_x = sin(angle)*radius and offset_y = cos(angle)*radius, rounded
// to the radius format and saturated. WrapCells is 33 minus
// clog2(360 * 2^FRACTION_BITS); a row of WrapCells conditional-subtract
// cells wraps the angle into one turn, one register folds the signed offset
// back and scales the radius by the rotation gain, one register splits off
// the quadrant, then one rotation cell per stage, then the output register.
// A skid register behind the output lets one more item in while a result is
// held; in_stall_o rises only when that skid register is full.
module polar_offset_degrees #(
  parameter int unsigned ROTATION_STAGES = 16,
  parameter int unsigned FRACTION_BITS   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] angle_deg_i,
  input  logic signed [23:0] radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] offset_x_o,
  output logic signed [23:0] offset_y_o
);
  import pod_pkg::*;

  localparam int unsigned StageCnt =
    (ROTATION_STAGES > MaxStages) ? MaxStages : ROTATION_STAGES;
  localparam longint unsigned FullTurnL  = 64'd360 << FRACTION_BITS;
  localparam longint unsigned HalfRangeL = 64'd1 << 31;
  localparam int unsigned     FullBits   = $clog2(FullTurnL);
  localparam int unsigned     WrapCells  = 33 - FullBits;
  localparam logic [32:0]     FullTurn   = 33'(FullTurnL);
  localparam logic [32:0]     FoldOffset = 33'(HalfRangeL % FullTurnL);
  localparam logic [31:0]     Quarter    = 32'(FullTurnL / 4);
  localparam int unsigned     ZShift     = AngleFrac - FRACTION_BITS;
  localparam logic signed [31:0] Gain    = signed'(POD_GAIN[StageCnt]);

  logic en;

  // Angle wrap chain. The sign bit is flipped so the angle becomes unsigned.
  logic      wrap_v [WrapCells+1];
  pod_wrap_t wrap_d [WrapCells+1];

  assign wrap_v[0]        = in_valid_i;
  assign wrap_d[0].rem    = {~angle_deg_i[31], angle_deg_i[30:0]};
  assign wrap_d[0].radius = radius_i;

  for (genvar g = 0; g < WrapCells; g++) begin : g_wrap
    pod_wrap_cell #(
      .SUB(33'(FullTurnL << (WrapCells - 1 - g)))
    ) u_wrap (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(wrap_v[g]),
      .data_i (wrap_d[g]),
      .valid_o(wrap_v[g+1]),
      .data_o (wrap_d[g+1])
    );
  end

  // Fold stage: undo the sign-bit offset and scale the radius by the gain.
  logic                    fold_valid_q;
  logic [31:0]             fold_ang_q, fold_ang_d;
  logic signed [DataW-1:0] fold_x_q, fold_x_d;
  logic [32:0]             fold_diff;
  logic signed [55:0]      fold_prod;

  always_comb begin
    fold_diff  = {1'b0, wrap_d[WrapCells].rem} - FoldOffset;
    if (fold_diff[32]) begin
      fold_diff = fold_diff + FullTurn;
    end
    fold_ang_d = fold_diff[31:0];
    fold_prod  = 56'(wrap_d[WrapCells].radius) * 56'(Gain);
    fold_x_d   = DataW'(fold_prod >>> 14);
  end

  // Quadrant stage: split the wrapped angle into quadrant and remainder.
  logic        quad_valid_q;
  pod_rot_t    quad_q, quad_d;
  logic [31:0] quad_rem;

  always_comb begin
    quad_d.x = fold_x_q;
    quad_d.y = '0;
    if (fold_ang_q >= 32'(Quarter * 3)) begin
      quad_d.quad = QUAD_3;
      quad_rem    = fold_ang_q - 32'(Quarter * 3);
    end else if (fold_ang_q >= 32'(Quarter * 2)) begin
      quad_d.quad = QUAD_2;
      quad_rem    = fold_ang_q - 32'(Quarter * 2);
    end else if (fold_ang_q >= Quarter) begin
      quad_d.quad = QUAD_1;
      quad_rem    = fold_ang_q - Quarter;
    end else begin
      quad_d.quad = QUAD_0;
      quad_rem    = fold_ang_q;
    end
    quad_d.z = signed'(quad_rem << ZShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
      quad_valid_q <= 1'b0;
    end else if (en) begin
      fold_valid_q <= wrap_v[WrapCells];
      quad_valid_q <= fold_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_ang_q <= fold_ang_d;
      fold_x_q   <= fold_x_d;
      quad_q     <= quad_d;
    end
  end

  // Rotation chain.
  logic     rot_v [StageCnt+1];
  pod_rot_t rot_d [StageCnt+1];

  assign rot_v[0] = quad_valid_q;
  assign rot_d[0] = quad_q;

  for (genvar g = 0; g < StageCnt; g++) begin : g_rot
    pod_rot_cell #(
      .STAGE(g)
    ) u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(rot_v[g]),
      .data_i (rot_d[g]),
      .valid_o(rot_v[g+1]),
      .data_o (rot_d[g+1])
    );
  end

  // Rounds half up, drops the 16 extra fraction bits and saturates.
  function automatic logic signed [23:0] round_sat(input logic signed [DataW-1:0] v);
    logic signed [DataW:0] sum;
    logic signed [DataW:0] shifted;
    sum     = (DataW+1)'(v) + (DataW+1)'(32'sd32768);
    shifted = sum >>> 16;
    if (shifted > (DataW+1)'(32'sd8388607)) begin
      return 24'sh7FFFFF;
    end else if (shifted < (DataW+1)'(-32'sd8388608)) begin
      return 24'sh800000;
    end
    return shifted[23:0];
  endfunction

  logic signed [DataW-1:0] cos_v, sin_v, ox, oy;
  logic signed [23:0]      res_x, res_y;

  always_comb begin
    cos_v = rot_d[StageCnt].x;
    sin_v = rot_d[StageCnt].y;
    unique case (rot_d[StageCnt].quad)
      QUAD_0: begin ox = sin_v;  oy = cos_v;  end
      QUAD_1: begin ox = cos_v;  oy = -sin_v; end
      QUAD_2: begin ox = -sin_v; oy = -cos_v; end
      QUAD_3: begin ox = -cos_v; oy = sin_v;  end
      default: begin ox = sin_v; oy = cos_v;  end
    endcase
    res_x = round_sat(ox);
    res_y = round_sat(oy);
  end

  // Output register with a skid register behind it.
  logic               out_valid_q, skid_valid_q;
  logic signed [23:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic               out_take, out_free, last_valid;

  assign en         = !skid_valid_q;
  assign last_valid = rot_v[StageCnt];
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (last_valid) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
      end
    end else if (last_valid) begin
      if (out_free) begin
        out_x_q <= res_x;
        out_y_q <= res_y;
      end else begin
        skid_x_q <= res_x;
        skid_y_q <= res_y;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign offset_x_o  = out_x_q;
  assign offset_y_o  = out_y_q;

endmodule

### design/pod_checker.sv
// Port-level checks of the polar offset pipeline and their bind.
`include "polar_offset_degrees_defines.svh"

module pod_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] offset_x_o,
  input logic signed [23:0] offset_y_o
);

  logic out_held;

  assign out_held = out_valid_o && out_stall_i;

  // The input side only stalls when a result is already waiting.
  `POD_ASSERT_CLK(a_stall_needs_result, in_stall_o |-> out_valid_o)

  // Stall on the input rises only after the output was held back.
  `POD_ASSERT_CLK(a_stall_rise, $rose(in_stall_o) |-> $past(out_held))

  // Stall on the input clears only after a result was taken.
  `POD_ASSERT_CLK(a_stall_fall, $fell(in_stall_o) |-> $past(out_valid_o && !out_stall_i))

  // A held result stays put until it is taken.
  `POD_ASSERT_CLK(a_out_hold, out_held |=> out_valid_o && $stable(offset_x_o) && $stable(offset_y_o))

endmodule

bind polar_offset_degrees pod_checker u_pod_checker (.*);
